@@ hdl/adq_pkg.sv @@
`timescale 1ns / 1ps
// adq_pkg: shared widths, limits, register indexes and types for the downmix decimator
// no dependencies; used by every module of the block

package adq_pkg;

    localparam int SAMPLE_W = 16;
    localparam int FSUM_W   = 19;
    localparam int GSUM_W   = 20;
    localparam int DIV_W    = 20;
    localparam int DVS_W    = 5;
    localparam int REM_W    = 4;
    localparam int DIV_STEP = 4;
    localparam int DIV_CYC  = DIV_W / DIV_STEP;
    localparam int DCNT_W   = 3;

    localparam int CH_W  = 4;
    localparam int RED_W = 5;
    localparam int QB_W  = 5;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REDUCE_FACTOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUANT_BITS    = 2'd2;

    localparam logic [CH_W-1:0]  MAX_CHANNELS = 4'd8;
    localparam logic [RED_W-1:0] MAX_REDUCE   = 5'd16;
    localparam logic [QB_W-1:0]  MAX_QBITS    = 5'd16;

    localparam logic [CH_W-1:0]  CH_RESET  = 4'd1;
    localparam logic [RED_W-1:0] RED_RESET = 5'd1;
    localparam logic [QB_W-1:0]  QB_RESET  = 5'd16;

    // effective (clamped) configuration
    typedef struct packed {
        logic [CH_W-1:0]  chans;
        logic [RED_W-1:0] red;
        logic [QB_W-1:0]  qb;
    } cfg_t;

    // request into the shared divider
    typedef struct packed {
        logic                     start;
        logic signed [DIV_W-1:0]  dividend;
        logic [DVS_W-1:0]         divisor;
    } div_req_t;

    // answer from the shared divider
    typedef struct packed {
        logic                     done;
        logic signed [DIV_W-1:0]  quotient;
    } div_rsp_t;

endpackage

@@ hdl/adq_front.sv @@
`timescale 1ns / 1ps
// adq_front: takes channel samples, builds the frame sum and hands closed frames on
// depends on adq_pkg

module adq_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  adq_pkg::cfg_t                       cfg,
    input  logic                                push,
    input  logic signed [adq_pkg::SAMPLE_W-1:0] sample,
    input  logic                                job_full,
    output logic                                full,
    output logic                                job_push,
    output logic signed [adq_pkg::FSUM_W-1:0]   job_sum
);

    logic [adq_pkg::CH_W-1:0]          idx_reg;
    logic [adq_pkg::CH_W-1:0]          idx_next;
    logic signed [adq_pkg::FSUM_W-1:0] fsum_reg;
    logic signed [adq_pkg::FSUM_W-1:0] fsum_add;
    logic                              accept;
    logic                              close;

    assign full     = job_full;
    assign accept   = push && !job_full;
    assign idx_next = idx_reg + adq_pkg::CH_W'(1);
    assign fsum_add = fsum_reg
                    + {{(adq_pkg::FSUM_W - adq_pkg::SAMPLE_W){sample[adq_pkg::SAMPLE_W-1]}},
                       sample};
    // frame closes once its count reaches the current channel count
    assign close    = idx_next >= cfg.chans;

    assign job_push = accept && close;
    assign job_sum  = fsum_add;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            fsum_reg <= '0;
        end
        else if (accept)
        begin
            if (close)
            begin
                idx_reg  <= '0;
                fsum_reg <= '0;
            end
            else
            begin
                idx_reg  <= idx_next;
                fsum_reg <= fsum_add;
            end
        end
    end

endmodule

@@ hdl/adq_job_queue.sv @@
`timescale 1ns / 1ps
// adq_job_queue: two-entry queue of closed frame sums between front and back
// depends on adq_pkg

module adq_job_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  logic signed [adq_pkg::FSUM_W-1:0] data_in,
    output logic                              full,
    input  logic                              pop,
    output logic signed [adq_pkg::FSUM_W-1:0] data_out,
    output logic                              empty
);

    logic signed [adq_pkg::FSUM_W-1:0] entry_reg [2];
    logic                              wr_ptr_reg;
    logic                              rd_ptr_reg;
    logic [1:0]                        count_reg;
    logic                              do_push;
    logic                              do_pop;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/adq_res_queue.sv @@
`timescale 1ns / 1ps
// adq_res_queue: two-entry queue of finished output samples
// depends on adq_pkg

module adq_res_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                push,
    input  logic signed [adq_pkg::SAMPLE_W-1:0] data_in,
    output logic                                full,
    input  logic                                pop,
    output logic signed [adq_pkg::SAMPLE_W-1:0] data_out,
    output logic                                empty
);

    logic signed [adq_pkg::SAMPLE_W-1:0] entry_reg [2];
    logic                                wr_ptr_reg;
    logic                                rd_ptr_reg;
    logic [1:0]                          count_reg;
    logic                                do_push;
    logic                                do_pop;

    assign full     = count_reg == 2'd2;
    assign empty    = count_reg == 2'd0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign data_out = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= data_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

@@ hdl/adq_divider.sv @@
`timescale 1ns / 1ps
// adq_divider: shared signed divider, truncates toward zero, four quotient bits a cycle
// depends on adq_pkg

module adq_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  adq_pkg::div_req_t req,
    output adq_pkg::div_rsp_t rsp
);

    logic [adq_pkg::DIV_W-1:0]  quo_reg;
    logic [adq_pkg::REM_W-1:0]  rem_reg;
    logic [adq_pkg::DVS_W-1:0]  dvs_reg;
    logic                       neg_reg;
    logic                       busy_reg;
    logic                       done_reg;
    logic [adq_pkg::DCNT_W-1:0] cnt_reg;

    logic [adq_pkg::DIV_W-1:0]  mag;
    logic [adq_pkg::DIV_W-1:0]  quo_step;
    logic [adq_pkg::REM_W-1:0]  rem_step;

    assign mag = req.dividend[adq_pkg::DIV_W-1] ? adq_pkg::DIV_W'(-req.dividend)
                                                 : adq_pkg::DIV_W'(req.dividend);

    // restoring division, DIV_STEP bits per cycle; remainder stays below the divisor
    always_comb
    begin
        logic [adq_pkg::REM_W:0] trial;
        quo_step = quo_reg;
        rem_step = rem_reg;
        for (int i = 0; i < adq_pkg::DIV_STEP; i++)
        begin
            trial    = {rem_step, quo_step[adq_pkg::DIV_W-1]};
            quo_step = {quo_step[adq_pkg::DIV_W-2:0], 1'b0};
            if (trial >= dvs_reg)
            begin
                trial       = trial - dvs_reg;
                quo_step[0] = 1'b1;
            end
            rem_step = trial[adq_pkg::REM_W-1:0];
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? $signed(adq_pkg::DIV_W'(-quo_reg)) : $signed(quo_reg);

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            quo_reg <= mag;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
            neg_reg <= req.dividend[adq_pkg::DIV_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_step;
            rem_reg <= rem_step;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == adq_pkg::DCNT_W'(adq_pkg::DIV_CYC - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + adq_pkg::DCNT_W'(1);
            end
        end
    end

endmodule

@@ hdl/adq_back.sv @@
`timescale 1ns / 1ps
// adq_back: frame mean, group sum, group mean and bit truncation of closed frames
// depends on adq_pkg; drives the shared adq_divider through div_req_t / div_rsp_t

module adq_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  adq_pkg::cfg_t                       cfg,
    input  logic                                job_empty,
    input  logic signed [adq_pkg::FSUM_W-1:0]   job_sum,
    output logic                                job_pop,
    output adq_pkg::div_req_t                   div_req,
    input  adq_pkg::div_rsp_t                   div_rsp,
    input  logic                                res_full,
    output logic                                res_push,
    output logic signed [adq_pkg::SAMPLE_W-1:0] res_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FRAME,
        ST_GROUP,
        ST_PUSH
    } state_t;

    localparam logic [adq_pkg::SAMPLE_W-1:0] ALL_ONES = '1;

    state_t                               state_reg;
    logic [adq_pkg::RED_W-1:0]            gidx_reg;
    logic signed [adq_pkg::GSUM_W-1:0]    gsum_reg;
    logic signed [adq_pkg::SAMPLE_W-1:0]  result_reg;

    logic [adq_pkg::RED_W-1:0]            gidx_inc;
    logic signed [adq_pkg::GSUM_W-1:0]    gsum_add;
    logic                                 group_close;
    logic [3:0]                           shamt;
    logic [adq_pkg::SAMPLE_W-1:0]         mask;

    assign gidx_inc    = gidx_reg + adq_pkg::RED_W'(1);
    assign gsum_add    = gsum_reg + adq_pkg::GSUM_W'(div_rsp.quotient);
    assign group_close = gidx_inc >= cfg.red;
    // qb is 1..16, so the shift fits in four bits
    assign shamt       = 4'(adq_pkg::MAX_QBITS - cfg.qb);
    assign mask        = ALL_ONES << shamt;
    assign res_data    = result_reg;

    always_comb
    begin
        job_pop          = 1'b0;
        res_push         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {job_sum[adq_pkg::FSUM_W-1], job_sum};
        div_req.divisor  = {1'b0, cfg.chans};
        case (state_reg)
            ST_IDLE:
            begin
                if (!job_empty)
                begin
                    job_pop       = 1'b1;
                    div_req.start = 1'b1;
                end
            end
            ST_FRAME:
            begin
                div_req.dividend = gsum_add;
                div_req.divisor  = cfg.red;
                div_req.start    = div_rsp.done && group_close;
            end
            ST_GROUP:
            begin
            end
            ST_PUSH:
            begin
                res_push = !res_full;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            gidx_reg   <= '0;
            gsum_reg   <= '0;
            result_reg <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (!job_empty)
                    begin
                        state_reg <= ST_FRAME;
                    end
                end
                ST_FRAME:
                begin
                    if (div_rsp.done)
                    begin
                        if (group_close)
                        begin
                            gidx_reg  <= '0;
                            gsum_reg  <= '0;
                            state_reg <= ST_GROUP;
                        end
                        else
                        begin
                            gidx_reg  <= gidx_inc;
                            gsum_reg  <= gsum_add;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_GROUP:
                begin
                    if (div_rsp.done)
                    begin
                        result_reg <= div_rsp.quotient[adq_pkg::SAMPLE_W-1:0] & mask;
                        state_reg  <= ST_PUSH;
                    end
                end
                ST_PUSH:
                begin
                    if (!res_full)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hdl/audio_downmix_decimate_quantize_unit.sv @@
`timescale 1ns / 1ps
// audio_downmix_decimate_quantize_unit: top level of the downmix / decimate / quantize block
// depends on adq_pkg, adq_front, adq_job_queue, adq_divider, adq_back, adq_res_queue
//
//   channel   ports                              transfer when
//   --------  ---------------------------------  --------------------------
//   input     push, full, sample[15:0]            push high, full low
//   result    empty, pop, quantized_sample[15:0]  pop high, empty low
//   config    cfg_write, cfg_index[1:0], cfg_data  cfg_write high
//
// channel samples keep flowing while the two-entry frame queue has room. each
// closed frame takes one frame-mean division in the shared divider, four
// quotient bits a cycle; a closed group adds a group-mean division and then
// a push of the output sample. reset clears counters, sums and queues and
// loads channel_count 1, reduce_factor 1, quant_bits 16. full rises only
// when the frame queue fills; a blocked output queue stalls the back end,
// which then fills the frame queue.

module audio_downmix_decimate_quantize_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input samples
    input  logic                                  push,
    output logic                                  full,
    input  logic signed [adq_pkg::SAMPLE_W-1:0]   sample,
    // output samples
    output logic                                  empty,
    input  logic                                  pop,
    output logic signed [adq_pkg::SAMPLE_W-1:0]   quantized_sample,
    // configuration writes
    input  logic                                  cfg_write,
    input  logic [adq_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [adq_pkg::CFG_DATA_W-1:0]        cfg_data
);

    // raw register values as written
    logic [adq_pkg::CH_W-1:0]  chans_reg;
    logic [adq_pkg::RED_W-1:0] red_reg;
    logic [adq_pkg::QB_W-1:0]  qb_reg;

    // effective values after clamping
    adq_pkg::cfg_t cfg;

    // front to back frame queue
    logic                              job_push;
    logic signed [adq_pkg::FSUM_W-1:0] job_sum_in;
    logic                              job_full;
    logic                              job_pop;
    logic signed [adq_pkg::FSUM_W-1:0] job_sum_out;
    logic                              job_empty;

    // shared divider
    adq_pkg::div_req_t div_req;
    adq_pkg::div_rsp_t div_rsp;

    // back to output queue
    logic                                res_push;
    logic signed [adq_pkg::SAMPLE_W-1:0] res_data;
    logic                                res_full;

    // config register file, writes beyond the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chans_reg <= adq_pkg::CH_RESET;
            red_reg   <= adq_pkg::RED_RESET;
            qb_reg    <= adq_pkg::QB_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                adq_pkg::REG_CHANNEL_COUNT: chans_reg <= cfg_data[adq_pkg::CH_W-1:0];
                adq_pkg::REG_REDUCE_FACTOR: red_reg   <= cfg_data[adq_pkg::RED_W-1:0];
                adq_pkg::REG_QUANT_BITS:    qb_reg    <= cfg_data[adq_pkg::QB_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // zero acts as one, anything above the limit acts as the limit
    always_comb
    begin
        if (chans_reg == '0)
            cfg.chans = adq_pkg::CH_W'(1);
        else if (chans_reg > adq_pkg::MAX_CHANNELS)
            cfg.chans = adq_pkg::MAX_CHANNELS;
        else
            cfg.chans = chans_reg;

        if (red_reg == '0)
            cfg.red = adq_pkg::RED_W'(1);
        else if (red_reg > adq_pkg::MAX_REDUCE)
            cfg.red = adq_pkg::MAX_REDUCE;
        else
            cfg.red = red_reg;

        if (qb_reg == '0)
            cfg.qb = adq_pkg::QB_W'(1);
        else if (qb_reg > adq_pkg::MAX_QBITS)
            cfg.qb = adq_pkg::MAX_QBITS;
        else
            cfg.qb = qb_reg;
    end

    // front: frame accumulation, one sample per cycle while the frame queue has room
    adq_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .push     (push),
        .sample   (sample),
        .job_full (job_full),
        .full     (full),
        .job_push (job_push),
        .job_sum  (job_sum_in)
    );

    // decouples the front from divider latency
    adq_job_queue u_job_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .data_in  (job_sum_in),
        .full     (job_full),
        .pop      (job_pop),
        .data_out (job_sum_out),
        .empty    (job_empty)
    );

    // one divider serves both the frame mean and the group mean
    adq_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // back: mean, grouping, truncation
    adq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .job_empty (job_empty),
        .job_sum   (job_sum_out),
        .job_pop   (job_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_data)
    );

    // output queue, the head sits on quantized_sample while empty is low
    adq_res_queue u_res_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (res_push),
        .data_in  (res_data),
        .full     (res_full),
        .pop      (pop),
        .data_out (quantized_sample),
        .empty    (empty)
    );

endmodule

@@ tb/sv/adq_mean_checker.sv @@
`timescale 1ns / 1ps
// adq_mean_checker: watches the sample, output and register ports of the downmix block,
// predicts each quantized output and compares it on transfer; depends on adq_pkg

module adq_mean_checker
    import adq_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic signed [SAMPLE_W-1:0]    sample,
    input  logic                          empty,
    input  logic                          pop,
    input  logic signed [SAMPLE_W-1:0]    quantized_sample,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    output int                            mismatch_count,
    output int                            pending_count
);

    // register copies, raw as written
    logic [CH_W-1:0]     chan_reg;
    logic [RED_W-1:0]    red_reg;
    logic [QB_W-1:0]     qb_reg;

    // frame and group accumulators
    int                  frame_fill;
    int                  frame_acc;
    int                  group_fill;
    int                  group_acc;

    logic [SAMPLE_W-1:0] expected_outputs[$];

    function automatic int clamp_setting(input int value, input int hi);
        if (value < 1)
            return 1;
        if (value > hi)
            return hi;
        return value;
    endfunction

    task automatic report_mismatch(input string what);
        $display("%0t ns  output check: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic absorb_sample(input logic signed [SAMPLE_W-1:0] s);
        int                  chans;
        int                  red;
        int                  qb;
        int                  mean;
        int                  avg;
        logic [SAMPLE_W-1:0] keep_mask;
        chans = clamp_setting(int'(chan_reg), int'(MAX_CHANNELS));
        red   = clamp_setting(int'(red_reg), int'(MAX_REDUCE));
        qb    = clamp_setting(int'(qb_reg), int'(MAX_QBITS));
        frame_acc += int'(s);
        frame_fill++;
        if (frame_fill >= chans)
        begin
            // int division truncates toward zero
            mean       = frame_acc / chans;
            frame_acc  = 0;
            frame_fill = 0;
            group_acc += mean;
            group_fill++;
            if (group_fill >= red)
            begin
                avg        = group_acc / red;
                group_acc  = 0;
                group_fill = 0;
                keep_mask  = 16'hffff << (16 - qb);
                expected_outputs = {expected_outputs, avg[SAMPLE_W-1:0] & keep_mask};
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        logic [SAMPLE_W-1:0] want;
        if (!rst_n)
        begin
            mismatch_count = 0;
            chan_reg   = CH_RESET;
            red_reg    = RED_RESET;
            qb_reg     = QB_RESET;
            frame_fill = 0;
            frame_acc  = 0;
            group_fill = 0;
            group_acc  = 0;
            expected_outputs.delete();
        end
        else
        begin
            // a sample at the same edge as a register write still sees the old value
            if (push && !full)
                absorb_sample(sample);
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_CHANNEL_COUNT: chan_reg = cfg_data[CH_W-1:0];
                    REG_REDUCE_FACTOR: red_reg  = cfg_data[RED_W-1:0];
                    REG_QUANT_BITS:    qb_reg   = cfg_data[QB_W-1:0];
                    default:           ;
                endcase
            end
            if (pop && !empty)
            begin
                if (expected_outputs.size() == 0)
                    report_mismatch($sformatf("output %h with nothing pending",
                                              quantized_sample));
                else
                begin
                    want = expected_outputs.pop_front();
                    if (quantized_sample !== want)
                        report_mismatch($sformatf("quantized_sample %h, predicted %h",
                                                  quantized_sample, want));
                end
            end
        end
        pending_count = expected_outputs.size();
    end

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: stimulus and verdict for audio_downmix_decimate_quantize_unit
// depends on adq_pkg, the block under test and adq_mean_checker

module tb_top;

    import adq_pkg::*;

    localparam int SAMPLE_TARGET = 1150;
    // settle wait that lets the back end finish pending frames, keep a wide margin
    localparam int SETTLE_CYCLES = 48;
    // index past the register list, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       push = 1'b0;
    logic                       full;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       empty;
    logic                       pop = 1'b0;
    logic signed [SAMPLE_W-1:0] quantized_sample;
    logic                       cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    int mismatch_count;
    int pending_count;
    int samples_sent = 0;
    int burst_left = 0;
    int pop_cycle = 0;

    always #4 clk = ~clk;

    audio_downmix_decimate_quantize_unit DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .sample           (sample),
        .empty            (empty),
        .pop              (pop),
        .quantized_sample (quantized_sample),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data)
    );

    adq_mean_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .push             (push),
        .full             (full),
        .sample           (sample),
        .empty            (empty),
        .pop              (pop),
        .quantized_sample (quantized_sample),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .mismatch_count   (mismatch_count),
        .pending_count    (pending_count)
    );

    // hard stop, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("tb_top failed");
        $finish;
    end

    // output side stalls: cycles through free flow, sparse random pops,
    // short periodic runs and long blocks that back the block up into full
    always @(negedge clk)
    begin
        if (!rst_n)
            pop = 1'b0;
        else
        begin
            case ((pop_cycle / 200) % 4)
                0:       pop = 1'b1;
                1:       pop = ($urandom_range(0, 3) == 0);
                2:       pop = ((pop_cycle % 16) < 5);
                default: pop = ((pop_cycle % 64) >= 40);
            endcase
            pop_cycle++;
        end
    end

    // register write, called at a falling edge, returns at the next one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // wait until every predicted output has transferred, then let the back
    // end finish frames that produce nothing before touching registers
    task automatic settle();
        push = 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // one sample transfer; push stays high across a burst
    task automatic send_sample(input logic [SAMPLE_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                push = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        push   = 1'b1;
        sample = value;
        do
            @(posedge clk);
        while (full);
        @(negedge clk);
        burst_left--;
        samples_sent++;
    endtask

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'(int'($urandom_range(0, 16)) - 8);
            3:       return {$urandom_range(0, 1) ? 2'b10 : 2'b01, 14'($urandom)};
            default: return 16'($urandom);
        endcase
    endfunction

    // mostly small legal values, sometimes the top value, sometimes any raw code
    function automatic logic [CFG_DATA_W-1:0] pick_setting(input int common_hi,
                                                          input int top);
        case ($urandom_range(0, 9))
            0:       return 5'($urandom_range(0, 31));
            1:       return 5'(top);
            default: return 5'($urandom_range(1, common_hi));
        endcase
    endfunction

    initial
    begin
        int n;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // pass-through settings, field extremes and alternating bit patterns
        write_reg(REG_CHANNEL_COUNT, 5'd1);
        write_reg(REG_REDUCE_FACTOR, 5'd1);
        write_reg(REG_QUANT_BITS, 5'd16);
        send_sample(16'h7fff);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hffff);
        send_sample(16'h5555);
        send_sample(16'haaaa);
        send_sample(16'h0001);
        settle();

        // negative frame sum truncates toward zero, then group mean and masking
        write_reg(REG_CHANNEL_COUNT, 5'd3);
        write_reg(REG_REDUCE_FACTOR, 5'd2);
        write_reg(REG_QUANT_BITS, 5'd12);
        send_sample(16'hffff);
        send_sample(16'hffff);
        send_sample(16'h0000);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        send_sample(16'h7fff);
        settle();

        // zero in every register acts as one
        write_reg(REG_CHANNEL_COUNT, 5'd0);
        write_reg(REG_REDUCE_FACTOR, 5'd0);
        write_reg(REG_QUANT_BITS, 5'd0);
        send_sample(16'h8001);
        send_sample(16'h7fff);
        settle();

        // channel code wraps to four bits, oversized quant_bits clamps,
        // a write past the register list changes nothing
        write_reg(REG_CHANNEL_COUNT, 5'd17);
        write_reg(REG_QUANT_BITS, 5'd31);
        write_reg(REG_UNMAPPED, 5'd31);
        send_sample(16'h1234);
        settle();

        // channel count lowered mid-frame: next sample closes the frame
        write_reg(REG_CHANNEL_COUNT, 5'd4);
        write_reg(REG_REDUCE_FACTOR, 5'd1);
        write_reg(REG_QUANT_BITS, 5'd16);
        send_sample(16'h8000);
        send_sample(16'h8000);
        send_sample(16'h8000);
        settle();
        write_reg(REG_CHANNEL_COUNT, 5'd2);
        send_sample(16'h8000);
        settle();

        // widest frames and groups with full-scale input
        write_reg(REG_CHANNEL_COUNT, 5'd8);
        write_reg(REG_REDUCE_FACTOR, 5'd16);
        repeat (128) send_sample(16'h8000);
        settle();
        write_reg(REG_QUANT_BITS, 5'd1);
        repeat (128) send_sample(16'h7fff);
        settle();

        // random phases; partial frames and groups carry over register changes
        while (samples_sent < SAMPLE_TARGET)
        begin
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_CHANNEL_COUNT, pick_setting(4, 8));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_REDUCE_FACTOR, pick_setting(4, 16));
            if ($urandom_range(0, 3) != 0)
                write_reg(REG_QUANT_BITS, pick_setting(16, 16));
            if ($urandom_range(0, 7) == 0)
                write_reg(REG_UNMAPPED, 5'($urandom_range(0, 31)));
            n = $urandom_range(1, 48);
            repeat (n) send_sample(random_sample());
            settle();
        end

        settle();
        if (mismatch_count == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/adq_pkg.sv
hdl/adq_front.sv
hdl/adq_job_queue.sv
hdl/adq_res_queue.sv
hdl/adq_divider.sv
hdl/adq_back.sv
hdl/audio_downmix_decimate_quantize_unit.sv
tb/sv/adq_mean_checker.sv
tb/sv/tb_top.sv
